// ===== design/pcm_fade_volume_stereo_pack_defines.svh =====
// assertion macros for the pcm fade volume block
`ifndef PCM_FADE_VOLUME_STEREO_PACK_DEFINES_SVH
`define PCM_FADE_VOLUME_STEREO_PACK_DEFINES_SVH

// same-cycle implication
`define PFV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pfv assertion failed");

// next-cycle implication
`define PFV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pfv assertion failed");

`endif

// ===== design/pfv_pkg.sv =====
// shared widths and constants for the pcm fade volume block
package pfv_pkg;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 24;
    localparam int FADE_W   = 12;
    localparam int VOL_W    = 16;
    localparam int PROD_W   = 33;
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] REG_CLIP_LENGTH = 2'd0;
    localparam logic [1:0] REG_FADE_LEN    = 2'd1;
    localparam logic [1:0] REG_VOLUME      = 2'd2;

    localparam logic [POS_W-1:0]    CLIP_LENGTH_RST = '0;
    localparam logic [FADE_W-1:0]   FADE_LEN_RST    = 12'd110;
    localparam logic [VOL_W-1:0]    VOLUME_RST      = 16'd256;

    localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

    typedef struct packed {
        logic start;
        logic done;
    } pfv_div_ctl_t;

endpackage

// ===== design/pfv_div.sv =====
// serial restoring divider for the fade ramp, truncating toward zero
module pfv_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [pfv_pkg::PROD_W-1:0]   dividend,
    input  logic        [pfv_pkg::FADE_W-1:0]   divisor,
    output logic                                done,
    output logic signed [pfv_pkg::SAMPLE_W-1:0] quotient
);

    logic [pfv_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                           done_reg;
    logic                           neg_reg;
    logic [pfv_pkg::FADE_W-1:0]     rem_reg;
    logic [pfv_pkg::SAMPLE_W-1:0]   q_reg;
    logic [pfv_pkg::PROD_W-1:0]     mag;
    logic [pfv_pkg::FADE_W:0]       trial;
    logic                           ge;
    logic [pfv_pkg::FADE_W:0]       diff;

    assign mag   = dividend[pfv_pkg::PROD_W-1] ? (~dividend + 1'b1) : dividend;
    assign trial = {rem_reg, q_reg[pfv_pkg::SAMPLE_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= pfv_pkg::DIV_CNT_W'(pfv_pkg::DIV_STEPS);
                neg_reg <= dividend[pfv_pkg::PROD_W-1];
                rem_reg <= {1'b0, mag[26:pfv_pkg::SAMPLE_W]};
                q_reg   <= mag[pfv_pkg::SAMPLE_W-1:0];
            end else if (cnt_reg != '0) begin
                rem_reg <= ge ? diff[pfv_pkg::FADE_W-1:0] : trial[pfv_pkg::FADE_W-1:0];
                q_reg   <= {q_reg[pfv_pkg::SAMPLE_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == pfv_pkg::DIV_CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(~q_reg + 1'b1) : $signed(q_reg);

endmodule

// ===== design/pcm_fade_volume_stereo_pack.sv =====
// Fades a mono pcm clip in and out, applies a Q8 volume with saturation and
// packs the result into a stereo frame. Each transaction is handled alone: an
// accepted sample is range checked, faded by a multiply and a 16-step serial
// divider inside a ramp, scaled by the volume, and zeroed past the clip.
// One shared 16x17 multiplier serves both the ramp scale and the volume. The
// result register lets the next sample enter while a frame waits to be taken.
`include "pcm_fade_volume_stereo_pack_defines.svh"

module pcm_fade_volume_stereo_pack (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample
    input  logic        s_tuser,   // start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // frame
    output logic        m_tuser,   // in_clip
    output logic        m_tlast,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_FADE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL_VOL,
        ST_FIN
    } state_t;

    state_t                                 state_reg;
    logic [pfv_pkg::POS_W-1:0]              clip_reg;
    logic [pfv_pkg::FADE_W-1:0]             fade_reg;
    logic [pfv_pkg::VOL_W-1:0]              vol_reg;
    logic [pfv_pkg::POS_W-1:0]              pos_reg;
    logic signed [pfv_pkg::SAMPLE_W-1:0]    sample_reg;
    logic [pfv_pkg::FADE_W-1:0]             fac_reg;
    logic signed [pfv_pkg::PROD_W-1:0]      prod_reg;
    logic                                   inside_reg;
    logic                                   m_tvalid_reg;
    logic [31:0]                            m_tdata_reg;
    logic                                   m_tuser_reg;
    logic                                   m_tlast_reg;

    logic                                   s_accept;
    logic                                   out_free;
    logic [pfv_pkg::POS_W-1:0]              remain;
    logic                                   in_range;
    logic                                   head;
    logic                                   tail;
    logic [pfv_pkg::POS_W-1:0]              pos_inc;
    logic signed [16:0]                     mul_b;
    logic signed [pfv_pkg::PROD_W-1:0]      mul_p;
    logic [24:0]                            y_full;
    logic                                   y_fits;
    logic [pfv_pkg::SAMPLE_W-1:0]           y_sat;
    logic [pfv_pkg::SAMPLE_W-1:0]           y_out;
    pfv_pkg::pfv_div_ctl_t                  div_ctl;
    logic signed [pfv_pkg::SAMPLE_W-1:0]    div_q;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign remain   = clip_reg - pos_reg;
    assign in_range = pos_reg < clip_reg;
    assign head     = pos_reg < {{(pfv_pkg::POS_W-pfv_pkg::FADE_W){1'b0}}, fade_reg};
    assign tail     = remain < {{(pfv_pkg::POS_W-pfv_pkg::FADE_W){1'b0}}, fade_reg};
    assign pos_inc  = pos_reg + 1'b1;

    assign mul_b = (state_reg == ST_MUL_FADE) ? $signed({5'b0, fac_reg})
                                              : $signed({1'b0, vol_reg});
    assign mul_p = sample_reg * mul_b;

    assign y_full = prod_reg[pfv_pkg::PROD_W-1:8];
    assign y_fits = (&y_full[24:15]) || !(|y_full[24:15]);
    assign y_sat  = y_fits ? y_full[15:0] : (y_full[24] ? pfv_pkg::SAT_NEG : pfv_pkg::SAT_POS);
    assign y_out  = inside_reg ? y_sat : '0;

    assign div_ctl.start = (state_reg == ST_DIV_GO);

    pfv_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_ctl.start),
        .dividend (prod_reg),
        .divisor  (fade_reg),
        .done     (div_ctl.done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_reg <= pfv_pkg::CLIP_LENGTH_RST;
            fade_reg <= pfv_pkg::FADE_LEN_RST;
            vol_reg  <= pfv_pkg::VOLUME_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                pfv_pkg::REG_CLIP_LENGTH: clip_reg <= cfg_wdata;
                pfv_pkg::REG_FADE_LEN:    fade_reg <= cfg_wdata[pfv_pkg::FADE_W-1:0];
                pfv_pkg::REG_VOLUME:      vol_reg  <= cfg_wdata[pfv_pkg::VOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        sample_reg <= $signed(s_tdata);
                        if (s_tuser) begin
                            pos_reg <= '0;
                        end
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    inside_reg <= in_range;
                    fac_reg    <= head ? pos_reg[pfv_pkg::FADE_W-1:0]
                                       : remain[pfv_pkg::FADE_W-1:0];
                    if (!in_range) begin
                        state_reg <= ST_FIN;
                    end else if (head || tail) begin
                        state_reg <= ST_MUL_FADE;
                    end else begin
                        state_reg <= ST_MUL_VOL;
                    end
                end
                ST_MUL_FADE: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_DIV_GO;
                end
                ST_DIV_GO: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_ctl.done) begin
                        sample_reg <= div_q;
                        state_reg  <= ST_MUL_VOL;
                    end
                end
                ST_MUL_VOL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {y_out, y_out};
                        m_tuser_reg  <= inside_reg;
                        m_tlast_reg  <= inside_reg && (pos_inc >= clip_reg);
                        if (inside_reg) begin
                            pos_reg <= pos_inc;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `PFV_ASSERT_NXT(a_accept_checks, s_accept, state_reg == ST_CHECK)
    `PFV_ASSERT_IMP(a_div_done_waited, div_ctl.done, state_reg == ST_DIV_WAIT)
    `PFV_ASSERT_IMP(a_stereo_dup, m_tvalid, m_tdata[31:16] == m_tdata[15:0])
    `PFV_ASSERT_IMP(a_silence, m_tvalid && !m_tuser, m_tdata == 32'd0 && !m_tlast)

endmodule

// ===== test/pcm_fade_volume_stereo_pack_tb.sv =====
// self-checking testbench for the pcm fade, volume and stereo pack block
module pcm_fade_volume_stereo_pack_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] frame;
        logic        in_clip;
        logic        last;
    } stereo_out_t;

    class fade_scoreboard;
        logic [23:0] clip_len;
        logic [11:0] ramp_len;
        logic [15:0] gain;
        logic [23:0] play_pos;
        stereo_out_t frames_due[$];
        int unsigned errors;

        function new();
            clip_len = 24'd0;
            ramp_len = 12'd110;
            gain     = 16'd256;
            play_pos = 24'd0;
            errors   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] val);
            case (idx)
                pfv_pkg::REG_CLIP_LENGTH: clip_len = val;
                pfv_pkg::REG_FADE_LEN:    ramp_len = val[11:0];
                pfv_pkg::REG_VOLUME:      gain     = val[15:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return frames_due.size();
        endfunction

        // fade, gain, saturate and duplicate one sample
        function void note_sample(logic [15:0] raw, logic start);
            stereo_out_t want;
            longint      scaled;
            longint      gained;
            logic [23:0] remain;
            logic [15:0] y;
            want   = '0;
            scaled = longint'($signed(raw));
            if (start) begin
                play_pos = 24'd0;
            end
            if (play_pos < clip_len) begin
                remain = clip_len - play_pos;
                if (play_pos < ramp_len) begin
                    scaled = (scaled * longint'(play_pos)) / longint'(ramp_len);
                end else if (remain < ramp_len) begin
                    scaled = (scaled * longint'(remain)) / longint'(ramp_len);
                end
                gained = (scaled * longint'(gain)) >>> 8;
                if (gained > 32767) begin
                    gained = 32767;
                end else if (gained < -32768) begin
                    gained = -32768;
                end
                y = gained[15:0];
                want.frame   = {y, y};
                want.in_clip = 1'b1;
                play_pos     = play_pos + 24'd1;
                want.last    = (play_pos >= clip_len);
            end
            frames_due.push_back(want);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            if (errors < 30) begin
                $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
            end
            errors++;
        endtask

        task check_frame(logic [31:0] frame, logic in_clip, logic last);
            stereo_out_t want;
            if (frames_due.size() == 0) begin
                report_mismatch("frame with nothing due", frame, 32'd0);
            end else begin
                want = frames_due.pop_front();
                if (frame !== want.frame) begin
                    report_mismatch("frame", frame, want.frame);
                end
                if (in_clip !== want.in_clip) begin
                    report_mismatch("in_clip", 32'(in_clip), 32'(want.in_clip));
                end
                if (last !== want.last) begin
                    report_mismatch("last", 32'(last), 32'(want.last));
                end
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wen   = 1'b0;
    logic [1:0]  cfg_index = pfv_pkg::REG_CLIP_LENGTH;
    logic [23:0] cfg_wdata = '0;

    fade_scoreboard board;
    bit             calm = 1'b0;
    int unsigned    sent = 0;

    pcm_fade_volume_stereo_pack dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 6);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                board.note_sample(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                board.check_frame(m_tdata, m_tuser, m_tlast);
            end
        end
    end

    initial begin
        #4ms;
        $display("pcm_fade_volume_stereo_pack_tb: errors");
        $finish;
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'hffff;
            3: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [15:0] smp, input logic start);
        while (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sent++;
    endtask

    task automatic drain_frames();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (30) @(posedge aclk);
    endtask

    // mask bit 0 clip length, bit 1 fade length, bit 2 volume
    task automatic program_regs(input bit [2:0] mask, input logic [23:0] clip,
                                input logic [23:0] fade, input logic [23:0] vol);
        logic [23:0] vals [3];
        logic [1:0]  idxs [3];
        vals = '{clip, fade, vol};
        idxs = '{pfv_pkg::REG_CLIP_LENGTH, pfv_pkg::REG_FADE_LEN, pfv_pkg::REG_VOLUME};
        for (int i = 0; i < 3; i++) begin
            if (mask[i]) begin
                cfg_wen   <= 1'b1;
                cfg_index <= idxs[i];
                cfg_wdata <= vals[i];
                @(posedge aclk);
                board.write_reg(idxs[i], vals[i]);
            end
        end
        cfg_wen <= 1'b0;
    endtask

    task automatic play_clip(input int unsigned n_items, input bit with_start);
        for (int unsigned i = 0; i < n_items; i++) begin
            send_sample(pick_sample(), (i == 0 && with_start) || ($urandom_range(99) < 2));
        end
    endtask

    initial begin
        logic [23:0] clip;
        logic [11:0] fade;
        logic [15:0] vol;
        int unsigned span;
        int unsigned phase;
        board = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty clip after reset gives silence
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h8000, 1'b0);
        drain_frames();

        // head ramp, middle, tail ramp, end of clip, then padding
        program_regs(3'b111, 24'd8, 24'd3, 24'd256);
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hffff, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h3039, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h1234, 1'b0);
        drain_frames();

        // no fade with full gain saturates both ways
        program_regs(3'b111, 24'd4, 24'd0, 24'hffff);
        send_sample(16'h7fff, 1'b1);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hffff, 1'b0);
        send_sample(16'h7fff, 1'b0);
        drain_frames();

        // both ramps overlap, head wins; zero volume
        program_regs(3'b111, 24'd5, 24'd10, 24'd0);
        play_clip(5, 1'b1);
        drain_frames();
        program_regs(3'b100, 24'd0, 24'd0, 24'd256);
        play_clip(5, 1'b1);
        drain_frames();

        // clip shrinks below the current position
        program_regs(3'b111, 24'd20, 24'd2, 24'd256);
        play_clip(6, 1'b1);
        drain_frames();
        program_regs(3'b001, 24'd3, 24'd0, 24'd0);
        send_sample(16'h4000, 1'b0);
        send_sample(16'hc000, 1'b0);
        send_sample(16'h4000, 1'b1);
        drain_frames();

        phase = 0;
        while (sent < 1330) begin
            calm = (phase >= 5 && phase < 11);
            case ($urandom_range(9))
                0: clip = 24'd0;
                1: clip = 24'd1;
                2: clip = 24'hffffff;
                default: clip = 24'($urandom_range(2, 80));
            endcase
            case ($urandom_range(7))
                0: fade = 12'd0;
                1: fade = 12'd1;
                2: fade = 12'hfff;
                default: fade = 12'($urandom_range(1, 40));
            endcase
            case ($urandom_range(7))
                0: vol = 16'd0;
                1: vol = 16'hffff;
                2: vol = 16'd256;
                default: vol = 16'($urandom_range(0, 1023));
            endcase
            program_regs(($urandom_range(4) == 0) ? 3'($urandom_range(1, 7)) : 3'b111,
                         clip, {12'($urandom), fade}, {8'($urandom), vol});
            for (int k = $urandom_range(1, 4); k > 0; k--) begin
                span = (clip > 100) ? $urandom_range(20, 120) : 32'(clip);
                play_clip(span + $urandom_range(0, 3), $urandom_range(9) != 0);
            end
            drain_frames();
            phase++;
        end
        calm = 1'b0;
        drain_frames();

        if (board.errors == 0) begin
            $display("pcm_fade_volume_stereo_pack_tb: clean");
        end else begin
            $display("pcm_fade_volume_stereo_pack_tb: errors");
        end
        $finish;
    end
endmodule
